// ===== design/miller_rabin_prime_test_unit_defines.svh =====
// assertion macros shared by the multiplier and controller design files
`ifndef MILLER_RABIN_PRIME_TEST_UNIT_DEFINES_SVH
`define MILLER_RABIN_PRIME_TEST_UNIT_DEFINES_SVH

// property that must hold on every clock edge outside reset
`define MRP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// property that must hold on every clock edge, reset included
`define MRP_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ===== design/mrp_pkg.sv =====
package mrp_pkg;

   localparam int WidthDefault = 64;
   localparam int NumBases     = 8;
   localparam int BaseIdxW     = 3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SHIFT,
      ST_BASE,
      ST_POW,
      ST_EVAL,
      ST_SQUARE,
      ST_SQEVAL,
      ST_DONE
   } state_type;

   // datapath commands
   typedef struct packed {
      logic load;        // capture candidate
      logic shift_odd;   // strip one trailing zero of the odd part
      logic base_init;   // start exponentiation for current base
      logic pow_start;   // start one modular multiply of the ladder
      logic sq_start;    // start one squaring of y
      logic next_base;   // advance base index
   } cmd_type;

   // datapath status
   typedef struct packed {
      logic lt_two;
      logic is_base;
      logic is_even;
      logic odd_done;    // odd part is odd
      logic mul_busy;
      logic pow_done;    // exponent exhausted
      logic y_one;
      logic y_nm1;
      logic sq_more;     // squaring count below s-1
      logic last_base;
   } status_type;

   function automatic logic [4:0] base_value(input logic [BaseIdxW-1:0] idx);
      logic [4:0] v;
      unique case (idx)
         3'd0: v = 5'd2;
         3'd1: v = 5'd3;
         3'd2: v = 5'd5;
         3'd3: v = 5'd7;
         3'd4: v = 5'd11;
         3'd5: v = 5'd13;
         3'd6: v = 5'd17;
         default: v = 5'd19;
      endcase
      return v;
   endfunction

endpackage

// ===== design/mrp_mulmod.sv =====
`include "miller_rabin_prime_test_unit_defines.svh"

module mrp_mulmod #(
   parameter int WIDTH = mrp_pkg::WidthDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] x,
   input  logic [WIDTH-1:0] y,
   input  logic [WIDTH-1:0] m,
   output logic             busy,
   output logic [WIDTH-1:0] prod
);
   // operands x, y are below m; one bit of y per cycle
   logic             busy_ff, busy_in;
   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH-1:0] add_ff, add_in;
   logic [WIDTH-1:0] bits_ff, bits_in;

   function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] a,
                                                input logic [WIDTH-1:0] b,
                                                input logic [WIDTH-1:0] md);
      logic [WIDTH-1:0] gap;
      gap = md - b;
      return (a >= gap) ? (a - gap) : (a + b);
   endfunction

   // shift-and-add step
   always_comb begin
      busy_in = busy_ff;
      acc_in  = acc_ff;
      add_in  = add_ff;
      bits_in = bits_ff;
      if (start) begin
         busy_in = 1'b1;
         acc_in  = '0;
         add_in  = x;
         bits_in = y;
      end else if (busy_ff) begin
         if (bits_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            if (bits_ff[0]) begin
               acc_in = add_mod(acc_ff, add_ff, m);
            end
            add_in  = add_mod(add_ff, add_ff, m);
            bits_in = bits_ff >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      acc_ff  <= acc_in;
      add_ff  <= add_in;
      bits_ff <= bits_in;
   end

   assign busy = busy_ff;
   assign prod = acc_ff;

   `MRP_ASSERT(a_start_idle, start |-> !busy_ff, "multiply started while busy")
   `MRP_ASSERT(a_busy_after_start, start |=> busy_ff, "multiply did not go busy")
   `MRP_ASSERT(a_bits_shrink, (busy_ff && bits_ff != '0 && !start) |=> (bits_ff == ($past(bits_ff) >> 1)), "bits not shifted")
endmodule

// ===== design/mrp_datapath.sv =====
module mrp_datapath #(
   parameter int WIDTH = mrp_pkg::WidthDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [63:0]         candidate,
   input  mrp_pkg::cmd_type    cmd,
   output mrp_pkg::status_type status
);
   localparam int CntW = $clog2(WIDTH + 1);

   logic [WIDTH-1:0] n_ff, n_in;
   logic [WIDTH-1:0] odd_ff, odd_in;
   logic [CntW-1:0]  twos_ff, twos_in;
   logic [CntW-1:0]  k_ff, k_in;
   logic [WIDTH-1:0] exp_ff, exp_in;
   logic [WIDTH-1:0] res_ff, res_in;
   logic [WIDTH-1:0] sq_ff, sq_in;
   logic             phase_ff, phase_in;  // 0: exponentiation ladder, 1: squaring of the result
   logic             wait_ff, wait_in;    // a product is pending write-back
   logic [mrp_pkg::BaseIdxW-1:0] bidx_ff, bidx_in;

   logic             mul_start;
   logic [WIDTH-1:0] mul_x, mul_y, mul_p;
   logic             mul_busy;
   logic [WIDTH-1:0] nm1;
   logic [WIDTH-1:0] base_raw;
   logic [WIDTH-1:0] base_w;
   logic             mul_ret;
   logic             relaunch;

   assign nm1      = n_ff - 1'b1;
   assign base_raw = WIDTH'(mrp_pkg::base_value(bidx_ff));
   assign mul_ret  = wait_ff && !mul_busy;
   // after multiplying into the result, launch the square of sq
   assign relaunch = mul_ret && !phase_ff && exp_ff[0];

   // base reduced modulo n; n is at least 9 here, so two subtractions suffice
   always_comb begin
      base_w = base_raw;
      if (base_w >= n_ff) begin
         base_w = base_w - n_ff;
      end
      if (base_w >= n_ff) begin
         base_w = base_w - n_ff;
      end
   end

   mrp_mulmod #(.WIDTH(WIDTH)) u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .x     (mul_x),
      .y     (mul_y),
      .m     (n_ff),
      .busy  (mul_busy),
      .prod  (mul_p)
   );

   // ladder step: multiply result when exponent bit set, then square; sq_start squares the result
   always_comb begin
      mul_start = relaunch;
      mul_x     = sq_ff;
      mul_y     = sq_ff;
      if (cmd.pow_start) begin
         mul_start = 1'b1;
         if (exp_ff[0]) begin
            mul_x = res_ff;
         end
      end else if (cmd.sq_start) begin
         mul_start = 1'b1;
         mul_x     = res_ff;
         mul_y     = res_ff;
      end
   end

   always_comb begin
      n_in     = n_ff;
      odd_in   = odd_ff;
      twos_in  = twos_ff;
      k_in     = k_ff;
      exp_in   = exp_ff;
      res_in   = res_ff;
      sq_in    = sq_ff;
      phase_in = phase_ff;
      wait_in  = wait_ff;
      bidx_in  = bidx_ff;
      if (cmd.load) begin
         n_in    = candidate[WIDTH-1:0];
         odd_in  = candidate[WIDTH-1:0] - 1'b1;
         twos_in = '0;
         bidx_in = '0;
      end
      if (cmd.shift_odd) begin
         odd_in  = odd_ff >> 1;
         twos_in = twos_ff + 1'b1;
      end
      if (cmd.base_init) begin
         exp_in   = odd_ff;
         res_in   = WIDTH'(1);
         sq_in    = base_w;
         phase_in = 1'b0;
         wait_in  = 1'b0;
         k_in     = CntW'(1);
      end
      if (cmd.pow_start) begin
         wait_in = 1'b1;
      end
      if (cmd.sq_start) begin
         wait_in  = 1'b1;
         phase_in = 1'b1;
         k_in     = k_ff + 1'b1;
      end
      // product write-back
      if (mul_ret) begin
         if (phase_ff) begin
            res_in  = mul_p;
            wait_in = 1'b0;
         end else if (exp_ff[0]) begin
            res_in = mul_p;
            exp_in = exp_ff & ~WIDTH'(1);
         end else begin
            sq_in   = mul_p;
            exp_in  = exp_ff >> 1;
            wait_in = 1'b0;
         end
      end
      if (cmd.next_base) begin
         bidx_in = bidx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wait_ff <= 1'b0;
      end else begin
         wait_ff <= wait_in;
      end
      n_ff     <= n_in;
      odd_ff   <= odd_in;
      twos_ff  <= twos_in;
      k_ff     <= k_in;
      exp_ff   <= exp_in;
      res_ff   <= res_in;
      sq_ff    <= sq_in;
      phase_ff <= phase_in;
      bidx_ff  <= bidx_in;
   end

   // base match against table
   logic hit;
   always_comb begin
      hit = 1'b0;
      for (int i = 0; i < mrp_pkg::NumBases; i++) begin
         if (n_ff == WIDTH'(mrp_pkg::base_value(mrp_pkg::BaseIdxW'(i)))) begin
            hit = 1'b1;
         end
      end
   end

   assign status.lt_two    = (n_ff < WIDTH'(2));
   assign status.is_base   = hit;
   assign status.is_even   = !n_ff[0];
   assign status.odd_done  = odd_ff[0];
   assign status.mul_busy  = mul_busy || wait_ff;
   assign status.pow_done  = (exp_ff == '0);
   assign status.y_one     = (res_ff == WIDTH'(1));
   assign status.y_nm1     = (res_ff == nm1);
   assign status.sq_more   = (k_ff < twos_ff);
   assign status.last_base = (bidx_ff == mrp_pkg::BaseIdxW'(mrp_pkg::NumBases - 1));
endmodule

// ===== design/mrp_control.sv =====
`include "miller_rabin_prime_test_unit_defines.svh"

module mrp_control (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_is_prime,
   input  mrp_pkg::status_type status,
   output mrp_pkg::cmd_type    cmd
);
   mrp_pkg::state_type state_ff, state_in;
   logic               verdict_ff, verdict_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mrp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      verdict_ff <= verdict_in;
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      verdict_in = verdict_ff;
      cmd        = '0;
      req_stall  = 1'b1;
      rsp_valid  = 1'b0;
      unique case (state_ff)
         mrp_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = mrp_pkg::ST_CHECK;
            end
         end
         mrp_pkg::ST_CHECK: begin
            priority if (status.lt_two) begin
               verdict_in = 1'b0;
               state_in   = mrp_pkg::ST_DONE;
            end else if (status.is_base) begin
               verdict_in = 1'b1;
               state_in   = mrp_pkg::ST_DONE;
            end else if (status.is_even) begin
               verdict_in = 1'b0;
               state_in   = mrp_pkg::ST_DONE;
            end else begin
               verdict_in = 1'b1;
               state_in   = mrp_pkg::ST_SHIFT;
            end
         end
         mrp_pkg::ST_SHIFT: begin
            if (status.odd_done) begin
               cmd.base_init = 1'b1;
               state_in      = mrp_pkg::ST_BASE;
            end else begin
               cmd.shift_odd = 1'b1;
            end
         end
         mrp_pkg::ST_BASE: begin
            if (!status.mul_busy) begin
               if (status.pow_done) begin
                  state_in = mrp_pkg::ST_EVAL;
               end else begin
                  cmd.pow_start = 1'b1;
                  state_in      = mrp_pkg::ST_POW;
               end
            end
         end
         mrp_pkg::ST_POW: begin
            state_in = mrp_pkg::ST_BASE;
         end
         mrp_pkg::ST_EVAL: begin
            if (status.y_one || status.y_nm1) begin
               state_in = mrp_pkg::ST_SQEVAL;
            end else if (status.sq_more) begin
               cmd.sq_start = 1'b1;
               state_in     = mrp_pkg::ST_SQUARE;
            end else begin
               verdict_in = 1'b0;
               state_in   = mrp_pkg::ST_DONE;
            end
         end
         mrp_pkg::ST_SQUARE: begin
            if (!status.mul_busy) begin
               if (status.y_one) begin
                  verdict_in = 1'b0;
                  state_in   = mrp_pkg::ST_DONE;
               end else if (status.y_nm1) begin
                  state_in = mrp_pkg::ST_SQEVAL;
               end else if (status.sq_more) begin
                  cmd.sq_start = 1'b1;
               end else begin
                  verdict_in = 1'b0;
                  state_in   = mrp_pkg::ST_DONE;
               end
            end
         end
         mrp_pkg::ST_SQEVAL: begin
            // this base passed
            if (status.last_base) begin
               state_in = mrp_pkg::ST_DONE;
            end else begin
               cmd.next_base = 1'b1;
               state_in      = mrp_pkg::ST_SHIFT;
            end
         end
         mrp_pkg::ST_DONE: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = mrp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mrp_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_is_prime = verdict_ff;

   `MRP_ASSERT(a_one_cmd, $onehot0({cmd.load, cmd.base_init, cmd.pow_start, cmd.sq_start}), "conflicting commands")
   `MRP_ASSERT(a_accept_idle, (req_valid && !req_stall) |=> (state_ff == mrp_pkg::ST_CHECK), "accept outside idle")
   `MRP_ASSERT(a_rsp_hold, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_is_prime)), "result dropped under stall")
endmodule

// ===== design/miller_rabin_prime_test_unit.sv =====
// Miller-Rabin primality test unit, bases 2 through 19.
// Input channel: req_valid / req_stall with req_candidate; a transfer happens
// when req_valid is high and req_stall low. Only the low WIDTH bits are used.
// Result channel: rsp_valid / rsp_stall with rsp_is_prime, one per request.
// One candidate is processed at a time; req_stall stays high from the
// accepted transfer until its result has been taken.
// Trivial cases (below two, a base, even) are settled in the check state.
// Otherwise about 8 * (2*WIDTH) modular multiplies run on the single
// shift-and-add multiplier; that multiplier sets the rate.
// Reset (synchronous, active high) returns the controller to idle and
// drops any item in flight. While the receiver stalls, rsp_valid and
// rsp_is_prime hold and no new request is taken.
module miller_rabin_prime_test_unit #(
   parameter int WIDTH = mrp_pkg::WidthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_candidate,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_is_prime
);
   mrp_pkg::cmd_type    cmd;
   mrp_pkg::status_type status;

   mrp_control u_control (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_is_prime (rsp_is_prime),
      .status       (status),
      .cmd          (cmd)
   );

   mrp_datapath #(.WIDTH(WIDTH)) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .candidate (req_candidate),
      .cmd       (cmd),
      .status    (status)
   );
endmodule
